>>> design/pld3_pkg.sv
package pld3_pkg;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int DIST_FRAC_DEF = 20;
    localparam int DIST_WIDTH = 32;

    typedef struct packed {
        logic [COORD_WIDTH_DEF-1:0] point_x;
        logic [COORD_WIDTH_DEF-1:0] point_y;
        logic [COORD_WIDTH_DEF-1:0] point_z;
        logic [COORD_WIDTH_DEF-1:0] anchor_x;
        logic [COORD_WIDTH_DEF-1:0] anchor_y;
        logic [COORD_WIDTH_DEF-1:0] anchor_z;
        logic [COORD_WIDTH_DEF-1:0] dir_x;
        logic [COORD_WIDTH_DEF-1:0] dir_y;
        logic [COORD_WIDTH_DEF-1:0] dir_z;
    } pld3_in_t;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] distance;
        logic                  zero_direction;
    } pld3_out_t;
endpackage

>>> design/point_line_distance_3d.sv
// channel | ports                      | word
// input   | s_valid s_ready s_data     | pld3_in_t (point, anchor, direction)
// result  | m_valid m_ready m_data     | pld3_out_t (distance, zero_direction)
// One word per cycle while m_ready does not stall; the square-root pipeline
// resolves one result bit per stage (32 stages).
// aresetn is synchronous and clears only the valid bits.
// A stall at m_ready freezes all stages together; nothing is dropped.
module point_line_distance_3d
    import pld3_pkg::*;
#(
    parameter int DIST_FRAC_BITS = DIST_FRAC_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pld3_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output pld3_out_t m_data
);
    localparam int CW = COORD_WIDTH_DEF;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;
    localparam int SW = 2 * XW + 2;
    localparam int VSW = 2 * CW + 2;
    localparam int NW = SW + 2 * DIST_FRAC_BITS;
    localparam int DNW = VSW + 27;
    localparam int NB = DIST_WIDTH;
    localparam int ACCW = NW + 2;
    localparam int LO = 26;
    localparam int HI = XW - LO;
    localparam int RDW = NB + DNW;

    logic en;
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: differences
    logic v1_reg;
    logic signed [DW-1:0] d1_reg [3];
    logic signed [CW-1:0] w1_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_valid;
        if (en) begin
            d1_reg[0] <= DW'($signed(s_data.anchor_x)) - DW'($signed(s_data.point_x));
            d1_reg[1] <= DW'($signed(s_data.anchor_y)) - DW'($signed(s_data.point_y));
            d1_reg[2] <= DW'($signed(s_data.anchor_z)) - DW'($signed(s_data.point_z));
            w1_reg[0] <= $signed(s_data.dir_x);
            w1_reg[1] <= $signed(s_data.dir_y);
            w1_reg[2] <= $signed(s_data.dir_z);
        end
    end

    // stage 2: cross products and direction squares
    logic v2_reg;
    logic signed [PW-1:0] p2_reg [6];
    logic [2*CW-1:0] q2_reg [3];
    logic z2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
        if (en) begin
            p2_reg[0] <= d1_reg[1] * PW'(w1_reg[2]);
            p2_reg[1] <= d1_reg[2] * PW'(w1_reg[1]);
            p2_reg[2] <= d1_reg[2] * PW'(w1_reg[0]);
            p2_reg[3] <= d1_reg[0] * PW'(w1_reg[2]);
            p2_reg[4] <= d1_reg[0] * PW'(w1_reg[1]);
            p2_reg[5] <= d1_reg[1] * PW'(w1_reg[0]);
            for (int i = 0; i < 3; i++)
                q2_reg[i] <= $unsigned((2*CW)'(w1_reg[i]) * (2*CW)'(w1_reg[i]));
            z2_reg <= (w1_reg[0] == '0) && (w1_reg[1] == '0) && (w1_reg[2] == '0);
        end
    end

    // stage 3: cross components as magnitudes, |v|^2
    logic v3_reg, z3_reg;
    logic [XW-1:0] c3_reg [3];
    logic [VSW-1:0] vs3_reg;
    always_ff @(posedge aclk) begin
        logic signed [XW-1:0] c;
        if (!aresetn) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c = XW'(p2_reg[2*i]) - XW'(p2_reg[2*i+1]);
                c3_reg[i] <= c[XW-1] ? XW'(-c) : XW'(c);
            end
            vs3_reg <= VSW'(q2_reg[0]) + VSW'(q2_reg[1]) + VSW'(q2_reg[2]);
            z3_reg <= z2_reg;
        end
    end

    // stage 4: partial products of the cross squares (high/low halves),
    // den = |v|^2 * 1e8
    logic v4_reg, z4_reg;
    logic [2*HI-1:0] hh4_reg [3];
    logic [HI+LO-1:0] hl4_reg [3];
    logic [2*LO-1:0] ll4_reg [3];
    logic [DNW-1:0] dn4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                hh4_reg[i] <= (2*HI)'(c3_reg[i][XW-1:LO]) * (2*HI)'(c3_reg[i][XW-1:LO]);
                hl4_reg[i] <= (HI+LO)'(c3_reg[i][XW-1:LO]) * (HI+LO)'(c3_reg[i][LO-1:0]);
                ll4_reg[i] <= (2*LO)'(c3_reg[i][LO-1:0]) * (2*LO)'(c3_reg[i][LO-1:0]);
            end
            dn4_reg <= DNW'(vs3_reg) * DNW'(27'd100000000);
            z4_reg <= z3_reg;
        end
    end

    // stage 5: squares of cross components
    logic v5_reg, z5_reg;
    logic [2*XW-1:0] s5_reg [3];
    logic [DNW-1:0] dn5_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en) v5_reg <= v4_reg;
        if (en) begin
            for (int i = 0; i < 3; i++)
                s5_reg[i] <= ((2*XW)'(hh4_reg[i]) << (2 * LO))
                           + ((2*XW)'(hl4_reg[i]) << (LO + 1))
                           + (2*XW)'(ll4_reg[i]);
            dn5_reg <= dn4_reg;
            z5_reg <= z4_reg;
        end
    end

    // square root of num/den: r^2*den <= num tracked by a remainder
    // rem = num - r^2*den; setting bit b adds (2*r*2^b + 2^2b)*den.
    // Each stage keeps r*den (rd) and shifts of den are free.
    logic           sv_reg [NB+1];
    logic           sz_reg [NB+1];
    logic [NB-1:0]  sr_reg [NB+1];
    logic [ACCW-1:0] srem_reg [NB+1];
    logic [RDW-1:0] srd_reg [NB+1];
    logic [DNW-1:0] sdn_reg [NB+1];

    // stage 6: numerator, loaded into the head of the root pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) sv_reg[0] <= 1'b0;
        else if (en) sv_reg[0] <= v5_reg;
        if (en) begin
            sz_reg[0] <= z5_reg;
            sr_reg[0] <= '0;
            srem_reg[0] <= ACCW'((NW'(s5_reg[0]) + NW'(s5_reg[1]) + NW'(s5_reg[2]))
                                 << (2 * DIST_FRAC_BITS));
            srd_reg[0] <= '0;
            sdn_reg[0] <= dn5_reg;
        end
    end

    for (genvar g = 0; g < NB; g++) begin : g_sqrt
        localparam int B = NB - 1 - g;
        logic [ACCW+2*NB:0] t;
        logic [ACCW+2*NB:0] rem_w;
        always_comb begin
            t = ((ACCW+2*NB+1)'(srd_reg[g]) << (B + 1))
              + ((ACCW+2*NB+1)'(sdn_reg[g]) << (2 * B));
            rem_w = (ACCW+2*NB+1)'(srem_reg[g]);
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) sv_reg[g+1] <= 1'b0;
            else if (en) sv_reg[g+1] <= sv_reg[g];
            if (en) begin
                sz_reg[g+1] <= sz_reg[g];
                sdn_reg[g+1] <= sdn_reg[g];
                if (t <= rem_w && sdn_reg[g] != '0) begin
                    sr_reg[g+1] <= sr_reg[g] | (NB'(1) << B);
                    srem_reg[g+1] <= ACCW'(rem_w - t);
                    srd_reg[g+1] <= srd_reg[g] + (RDW'(sdn_reg[g]) << B);
                end else begin
                    sr_reg[g+1] <= sr_reg[g];
                    srem_reg[g+1] <= srem_reg[g];
                    srd_reg[g+1] <= srd_reg[g];
                end
            end
        end
    end

    // output word
    logic m_valid_reg;
    pld3_out_t m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en) m_valid_reg <= sv_reg[NB];
        if (en) begin
            m_data_reg.distance <= sz_reg[NB] ? '0 : sr_reg[NB];
            m_data_reg.zero_direction <= sz_reg[NB];
        end
    end
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;
endmodule

>>> design/pld3_checker.sv
module pld3_checker
    import pld3_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input pld3_out_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed under stall");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_direction |-> m_data.distance == '0)
        else $error("nonzero distance with zero direction");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind point_line_distance_3d pld3_checker u_pld3_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

>>> tb/sv/point_line_distance_3d_tb.sv
module point_line_distance_3d_tb;
    import pld3_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int FRAC = DIST_FRAC_DEF;
    localparam int LATENCY = 39;
    localparam int N_RANDOM = 1430;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    pld3_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    pld3_out_t m_data;

    pld3_out_t dist_q[$];
    int        errors;
    logic      hold_off;
    logic      all_sent;

    point_line_distance_3d dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // exact integer distance: |c|^2 * 2^(2F) compared with r^2 * |v|^2 * 1e8
    function automatic pld3_out_t calc_distance(pld3_in_t w);
        logic signed [63:0] dx, dy, dz, vx, vy, vz;
        logic signed [127:0] cx, cy, cz;
        logic [255:0] num, den, cand, r, t;
        pld3_out_t res;
        dx = $signed(w.anchor_x) - $signed(w.point_x);
        dy = $signed(w.anchor_y) - $signed(w.point_y);
        dz = $signed(w.anchor_z) - $signed(w.point_z);
        vx = $signed(w.dir_x);
        vy = $signed(w.dir_y);
        vz = $signed(w.dir_z);
        res.distance = '0;
        res.zero_direction = 1'b0;
        if (vx == 0 && vy == 0 && vz == 0) begin
            res.zero_direction = 1'b1;
            return res;
        end
        cx = dy * vz - dz * vy;
        cy = dz * vx - dx * vz;
        cz = dx * vy - dy * vx;
        num = 256'(cx * cx) + 256'(cy * cy) + 256'(cz * cz);
        num = num << (2 * FRAC);
        den = 256'(vx * vx) + 256'(vy * vy) + 256'(vz * vz);
        den = den * 256'd100000000;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = r | (256'd1 << b);
            t = cand * cand * den;
            if (t <= num) r = cand;
        end
        res.distance = r[31:0];
        return res;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return CW'($signed($urandom_range(0, 40)) - 20);
            3: return CW'($signed($urandom_range(0, 4000)) - 2000);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic pld3_in_t rand_word();
        pld3_in_t w;
        w.point_x = rand_coord();  w.point_y = rand_coord();  w.point_z = rand_coord();
        w.anchor_x = rand_coord(); w.anchor_y = rand_coord(); w.anchor_z = rand_coord();
        w.dir_x = rand_coord();    w.dir_y = rand_coord();    w.dir_z = rand_coord();
        case ($urandom_range(0, 19))
            0: {w.dir_x, w.dir_y, w.dir_z} = '0;
            1: begin
                w.dir_y = '0;
                w.dir_z = '0;
            end
            2: {w.anchor_x, w.anchor_y, w.anchor_z} = {w.point_x, w.point_y, w.point_z};
            default: ;
        endcase
        return w;
    endfunction

    typedef struct {
        pld3_in_t  word;
        logic      known;
        pld3_out_t result;
    } stim_row_t;

    localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] TEN  = CW'(10000);
    localparam logic [CW-1:0] NEG1 = {CW{1'b1}};

    stim_row_t stim_table[] = '{
        // zero direction, regardless of points
        '{'{'0, '0, '0, '0, '0, '0, '0, '0, '0}, 1'b1, '{32'd0, 1'b1}},
        '{'{MAXC, MINC, MAXC, MINC, MAXC, MINC, '0, '0, '0}, 1'b1, '{32'd0, 1'b1}},
        // point on the line
        '{'{'0, '0, '0, '0, '0, '0, ONE, '0, '0}, 1'b1, '{32'd0, 1'b0}},
        '{'{TEN, TEN, TEN, TEN, TEN, TEN, MAXC, MAXC, MAXC}, 1'b1, '{32'd0, 1'b0}},
        // unit offset 1.0 from a coordinate axis: distance 1.0
        '{'{'0, TEN, '0, '0, '0, '0, ONE, '0, '0}, 1'b1, '{32'h0010_0000, 1'b0}},
        '{'{'0, '0, TEN, '0, '0, '0, '0, MINC, '0}, 1'b1, '{32'h0010_0000, 1'b0}},
        '{'{TEN, '0, '0, '0, '0, '0, '0, '0, NEG1}, 1'b1, '{32'h0010_0000, 1'b0}},
        // extremes, predicted
        '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC, ONE, '0, '0}, 1'b0, '{32'd0, 1'b0}},
        '{'{MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, MAXC, ONE}, 1'b0, '{32'd0, 1'b0}},
        '{'{MINC, MAXC, '0, MAXC, MINC, '0, '0, '0, MAXC}, 1'b0, '{32'd0, 1'b0}},
        '{'{MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC}, 1'b0, '{32'd0, 1'b0}},
        '{'{NEG1, NEG1, NEG1, ONE, ONE, ONE, NEG1, ONE, NEG1}, 1'b0, '{32'd0, 1'b0}},
        '{'{MINC, '0, MAXC, '0, MINC, '0, MAXC, MINC, MAXC}, 1'b0, '{32'd0, 1'b0}}
    };

    task automatic send_word(input pld3_in_t w);
        s_data <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic push_word(input pld3_in_t w, input logic known, input pld3_out_t r);
        dist_q.push_back(known ? r : calc_distance(w));
        send_word(w);
    endtask

    task automatic idle_gap(input int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // sender
    initial begin
        int burst;
        errors = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        all_sent = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (stim_table[i]) begin
            push_word(stim_table[i].word, stim_table[i].known, stim_table[i].result);
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 3));
        end
        idle_gap(0);
        while (dist_q.size() != 0) @(negedge aclk);
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 60);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
                pld3_in_t w;
                w = rand_word();
                push_word(w, 1'b0, '0);
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
            if (n > 700 && n < 761) begin
                idle_gap(0);
                while (dist_q.size() != 0) @(negedge aclk);
            end
        end
        s_valid <= 1'b0;
        all_sent <= 1'b1;
    end

    // receiver stall pattern plus one long hold-off
    initial begin
        int cyc;
        m_ready = 1'b0;
        hold_off = 1'b0;
        cyc = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc == 400) hold_off = 1'b1;
            if (cyc == 800) hold_off = 1'b0;
            if (hold_off) m_ready <= 1'b0;
            else if ((cyc / 200) % 3 == 0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 9) < 6);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (dist_q.size() == 0) begin
                $display("%0t unexpected word: got dist=%h zd=%b", $time,
                         m_data.distance, m_data.zero_direction);
                errors++;
            end else begin
                pld3_out_t e;
                e = dist_q.pop_front();
                if (e.distance !== m_data.distance) begin
                    $display("%0t distance: expected %h got %h", $time,
                             e.distance, m_data.distance);
                    errors++;
                end
                if (e.zero_direction !== m_data.zero_direction) begin
                    $display("%0t zero_direction: expected %b got %b", $time,
                             e.zero_direction, m_data.zero_direction);
                    errors++;
                end
            end
        end
    end

    initial begin
        @(posedge all_sent);
        while (dist_q.size() != 0) @(posedge aclk);
        repeat (LATENCY * 2) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
